// ===== src/stereo_fir_q15_lowpass_assert.svh =====
// assertion macros shared by the stereo fir block
`ifndef STEREO_FIR_Q15_LOWPASS_ASSERT_SVH
`define STEREO_FIR_Q15_LOWPASS_ASSERT_SVH

// same-cycle implication under synchronous active-low reset
`define SFIR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sfir assertion failed");

// next-cycle implication under synchronous active-low reset
`define SFIR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sfir assertion failed");

`endif

// ===== src/sfir_pkg.sv =====
// shared constants, coefficient table and control types of the stereo fir block
`default_nettype none

package sfir_pkg;

    localparam int TAPS_DEFAULT = 101;
    localparam int ROM_DEPTH    = 101;
    localparam int COEF_W       = 10;
    localparam int SAMPLE_W     = 16;
    localparam int ACC_W        = 32;
    localparam int PROD_W       = COEF_W + 1 + SAMPLE_W;
    localparam int Q_SHIFT      = 15;
    localparam int ROM_IDX_W    = 8;

    // 1 khz low-pass at 96 khz sampling, peak at the centre tap
    localparam logic [COEF_W-1:0] LP_TABLE [ROM_DEPTH] = '{
        10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd1,   10'd2,   10'd4,   10'd6,
        10'd9,   10'd12,  10'd17,  10'd23,  10'd29,  10'd37,  10'd46,  10'd56,  10'd68,
        10'd81,  10'd95,  10'd111, 10'd128, 10'd146, 10'd166, 10'd186, 10'd208, 10'd231,
        10'd255, 10'd279, 10'd304, 10'd330, 10'd356, 10'd382, 10'd408, 10'd434, 10'd459,
        10'd484, 10'd508, 10'd531, 10'd553, 10'd574, 10'd594, 10'd612, 10'd628, 10'd642,
        10'd654, 10'd664, 10'd672, 10'd678, 10'd682, 10'd683, 10'd682, 10'd678, 10'd672,
        10'd664, 10'd654, 10'd642, 10'd628, 10'd612, 10'd594, 10'd574, 10'd553, 10'd531,
        10'd508, 10'd484, 10'd459, 10'd434, 10'd408, 10'd382, 10'd356, 10'd330, 10'd304,
        10'd279, 10'd255, 10'd231, 10'd208, 10'd186, 10'd166, 10'd146, 10'd128, 10'd111,
        10'd95,  10'd81,  10'd68,  10'd56,  10'd46,  10'd37,  10'd29,  10'd23,  10'd17,
        10'd12,  10'd9,   10'd6,   10'd4,   10'd2,   10'd1,   10'd0,   10'd0,   10'd0,
        10'd0,   10'd0
    };

    typedef struct packed {
        logic start;     // item accepted: write sample, reset accumulator
        logic issue;     // read one tap this cycle
        logic load_out;  // move accumulator into the output register
    } sfir_cmd_t;

    typedef struct packed {
        logic tap_last;  // the tap being issued is the last one
        logic pipe_idle; // no tap left in the mac pipeline
    } sfir_stat_t;

    // taps beyond the table use a zero coefficient
    function automatic logic [COEF_W-1:0] coef_at(input logic [ROM_IDX_W-1:0] k);
        logic [COEF_W-1:0] c;
        c = '0;
        if (k < ROM_IDX_W'(ROM_DEPTH)) begin
            c = LP_TABLE[k[6:0]];
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== src/sfir_ctrl.sv =====
// sequencer of the stereo fir block: accept, tap issue, drain and output handshake
`default_nettype none

module sfir_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    input  wire sfir_pkg::sfir_stat_t stat,
    output sfir_pkg::sfir_cmd_t     cmd
);
    import sfir_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    // output register may be refilled once its item is gone or leaving
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.start    = s_valid && (state_reg == ST_IDLE);
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                cmd.issue = 1'b1;
                if (stat.tap_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (stat.pipe_idle && out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/sfir_dp.sv =====
// datapath of the stereo fir block: history memory, coefficient rom, mac pipeline
`default_nettype none

module sfir_dp #(
    parameter int TAPS = sfir_pkg::TAPS_DEFAULT
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire sfir_pkg::sfir_cmd_t                  cmd,
    output sfir_pkg::sfir_stat_t                      stat,
    input  wire logic                                 channel,
    input  wire logic signed [sfir_pkg::SAMPLE_W-1:0] sample_in,
    output logic signed [sfir_pkg::SAMPLE_W-1:0]      sample_out
);
    import sfir_pkg::*;

    localparam int PW        = $clog2(TAPS);
    localparam int CW        = $clog2(TAPS + 1);
    localparam int AW        = PW + 1;
    localparam int MEM_DEPTH = 2 ** AW;

    // per channel circular buffer of TAPS samples, newest included
    logic signed [SAMPLE_W-1:0] hist_mem [MEM_DEPTH];

    logic [PW-1:0] wptr_reg [2];
    logic [PW-1:0] wptr_next [2];
    logic [CW-1:0] cnt_reg [2];
    logic [CW-1:0] cnt_next [2];

    logic          ch_reg, ch_next;
    logic [PW-1:0] rp_reg, rp_next;
    logic [PW-1:0] k_reg, k_next;
    logic          rd_vld_reg, rd_vld_next;
    logic          prod_vld_reg, prod_vld_next;

    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic [COEF_W-1:0]          coef_reg;
    logic                       rd_live_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [SAMPLE_W-1:0] out_reg;

    logic [PW-1:0]              wptr_cur;
    logic [CW-1:0]              cnt_cur;
    logic [AW-1:0]              wr_addr;
    logic [AW-1:0]              rd_addr;
    logic                       tap_live;
    logic signed [SAMPLE_W-1:0] mac_data;

    assign wptr_cur   = wptr_reg[channel];
    assign wr_addr    = {channel, wptr_cur};
    assign rd_addr    = {ch_reg, rp_reg};
    assign cnt_cur    = cnt_reg[ch_reg];
    // entries never written since reset read as zero
    assign tap_live   = (CW'(k_reg) < cnt_cur);
    assign mac_data   = rd_live_reg ? rd_data_reg : '0;
    assign sample_out = out_reg;

    assign stat.tap_last  = (k_reg == PW'(TAPS - 1));
    assign stat.pipe_idle = !rd_vld_reg && !prod_vld_reg;

    always_comb begin
        wptr_next     = wptr_reg;
        cnt_next      = cnt_reg;
        ch_next       = ch_reg;
        rp_next       = rp_reg;
        k_next        = k_reg;
        rd_vld_next   = cmd.issue;
        prod_vld_next = rd_vld_reg;
        if (cmd.start) begin
            ch_next = channel;
            rp_next = wptr_cur;
            k_next  = '0;
            if (wptr_cur == PW'(TAPS - 1)) begin
                wptr_next[channel] = '0;
            end else begin
                wptr_next[channel] = wptr_cur + 1'b1;
            end
            if (cnt_reg[channel] != CW'(TAPS)) begin
                cnt_next[channel] = cnt_reg[channel] + 1'b1;
            end
        end else if (cmd.issue) begin
            // walk from newest to oldest
            if (rp_reg == '0) begin
                rp_next = PW'(TAPS - 1);
            end else begin
                rp_next = rp_reg - 1'b1;
            end
            k_next = k_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg[0]  <= '0;
            wptr_reg[1]  <= '0;
            cnt_reg[0]   <= '0;
            cnt_reg[1]   <= '0;
            ch_reg       <= 1'b0;
            rp_reg       <= '0;
            k_reg        <= '0;
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end else begin
            wptr_reg     <= wptr_next;
            cnt_reg      <= cnt_next;
            ch_reg       <= ch_next;
            rp_reg       <= rp_next;
            k_reg        <= k_next;
            rd_vld_reg   <= rd_vld_next;
            prod_vld_reg <= prod_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            hist_mem[wr_addr] <= sample_in;
        end
        if (cmd.issue) begin
            rd_data_reg <= hist_mem[rd_addr];
            coef_reg    <= coef_at(ROM_IDX_W'(k_reg));
            rd_live_reg <= tap_live;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_vld_reg) begin
            prod_reg <= PROD_W'($signed({1'b0, coef_reg})) * PROD_W'(mac_data);
        end
        if (cmd.start) begin
            acc_reg <= '0;
        end else if (prod_vld_reg) begin
            // wraps modulo 2^32
            acc_reg <= acc_reg + {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
        if (cmd.load_out) begin
            out_reg <= acc_reg[Q_SHIFT +: SAMPLE_W];
        end
    end

endmodule

`default_nettype wire

// ===== src/stereo_fir_q15_lowpass.sv =====
// stereo fir low-pass, top level: stream ports, sequencer and datapath
//
// two-channel 101-tap q15 low-pass filter on stream channels.
// s_tuser selects the channel (0 left, 1 right), s_tdata carries the signed
// 16-bit sample; each accepted item yields exactly one filtered item on m_.
// the sample is written into that channel's circular history memory, then a
// single multiply-accumulate unit walks the taps newest to oldest, one tap a
// cycle through a memory read, a registered product and a 32-bit add.
// the block takes no new item before the last one has left the mac pipeline,
// since the one memory read port and the multiplier are shared.
// s_tready is high only while no item is in progress; a finished item waits
// in the output register and the next input item is taken meanwhile. if the
// receiver stalls longer than one item's work, the finished sum waits in the
// datapath and the input side stays closed until the output register frees.
// reset clears both channels' fill counts and write pointers, so history
// reads as zero until written; no clearing pass is needed.
`default_nettype none

module stereo_fir_q15_lowpass #(
    parameter int TAPS = sfir_pkg::TAPS_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] sample_in
    input  wire logic        s_tuser,   // [0] channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata    // [15:0] sample_out
);
    import sfir_pkg::*;

    `include "stereo_fir_q15_lowpass_assert.svh"

    sfir_cmd_t                  cmd;
    sfir_stat_t                 stat;
    logic signed [SAMPLE_W-1:0] sample_out;

    sfir_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    sfir_dp #(
        .TAPS (TAPS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .channel    (s_tuser),
        .sample_in  ($signed(s_tdata)),
        .sample_out (sample_out)
    );

    assign m_tdata = $unsigned(sample_out);

    `SFIR_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `SFIR_ASSERT_NEXT(a_issue_stops, aclk, aresetn, cmd.issue && stat.tap_last, !cmd.issue)
    `SFIR_ASSERT_NOW(a_load_when_drained, aclk, aresetn, cmd.load_out, stat.pipe_idle)
    `SFIR_ASSERT_NOW(a_no_issue_on_start, aclk, aresetn, cmd.start, !cmd.issue && !cmd.load_out)

endmodule

`default_nettype wire

// ===== sim/stereo_fir_q15_lowpass_test.sv =====
// self-checking testbench for the stereo q15 low-pass fir: stream stimulus, predictor, checks

module stereo_fir_q15_lowpass_test;

    localparam int TAPS        = sfir_pkg::TAPS_DEFAULT;
    localparam int ITEM_TARGET = 750;
    localparam int CALM_FIRST  = 300;
    localparam int CALM_LAST   = 450;

    typedef enum bit {
        CH_LEFT  = 1'b0,
        CH_RIGHT = 1'b1
    } channel_e;

    // predicts filtered samples and holds them until the block returns them
    class lowpass_scoreboard;
        logic signed [15:0] history [2][TAPS-1];
        logic [15:0]        expected_samples [$];
        int                 mismatches;

        function new();
            foreach (history[c, k]) history[c][k] = '0;
            mismatches = 0;
        endfunction

        function int coef(int k);
            if (k < sfir_pkg::ROM_DEPTH) begin
                return int'(sfir_pkg::LP_TABLE[k]);
            end
            return 0;
        endfunction

        function void accept_sample(channel_e ch, logic signed [15:0] x);
            int acc;
            acc = coef(0) * int'(x);
            for (int k = 1; k < TAPS; k++) begin
                acc += coef(k) * int'(history[ch][k-1]);
            end
            expected_samples.push_back(acc[30:15]);
            for (int k = TAPS - 2; k > 0; k--) begin
                history[ch][k] = history[ch][k-1];
            end
            history[ch][0] = x;
        endfunction

        function void check_filtered(logic [15:0] actual);
            logic [15:0] want;
            if (expected_samples.size() == 0) begin
                $error("sample_out: expected none, actual %0d", $signed(actual));
                mismatches++;
                return;
            end
            want = expected_samples.pop_front();
            if (actual !== want) begin
                $error("sample_out: expected %0d, actual %0d", $signed(want), $signed(actual));
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    lowpass_scoreboard board = new();
    bit calm = 1'b0;
    int items_sent = 0;

    stereo_fir_q15_lowpass dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [15:0] sample_in
        .s_tuser  (s_tuser),    // [0] channel
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)     // [15:0] sample_out
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 8);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_filtered(m_tdata);
        end
    end

    task automatic send_item(channel_e ch, logic [15:0] smp);
        @(negedge aclk);
        while (!calm && $urandom_range(0, 99) < 8) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ch;
        s_tdata  <= smp;
        do @(posedge aclk); while (!s_tready);
        board.accept_sample(ch, smp);
        items_sent++;
        calm = (items_sent >= CALM_FIRST && items_sent < CALM_LAST);
    endtask

    task automatic hold_until_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_sample();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0:       v = 16'h7fff;
            1:       v = 16'h8000;
            2:       v = 16'h0000;
            3:       v = 16'($signed($urandom_range(0, 511)) - 256);
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    initial begin
        channel_e ch;
        logic [15:0] level;
        int run;

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // impulse on left, right stays silent until its own items arrive
        send_item(CH_LEFT, 16'h7fff);
        repeat (4) send_item(CH_LEFT, 16'h0000);
        send_item(CH_RIGHT, 16'h8000);
        send_item(CH_LEFT, 16'h0000);
        send_item(CH_RIGHT, 16'h7fff);
        send_item(CH_RIGHT, 16'h8000);
        send_item(CH_LEFT, 16'hffff);
        send_item(CH_LEFT, 16'h0001);
        send_item(CH_RIGHT, 16'h5555);
        send_item(CH_RIGHT, 16'haaaa);
        send_item(CH_LEFT, 16'h8000);
        send_item(CH_LEFT, 16'h8000);
        send_item(CH_RIGHT, 16'h0000);
        send_item(CH_LEFT, 16'h7fff);
        send_item(CH_RIGHT, 16'h7fff);
        hold_until_drained();

        while (items_sent < ITEM_TARGET) begin
            ch = channel_e'($urandom_range(0, 1));
            case ($urandom_range(0, 4))
                // full-scale dc run fills the whole history, near or past wrap
                0: begin
                    level = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
                    run = $urandom_range(TAPS, TAPS + 10);
                    repeat (run) send_item(ch, level);
                end
                1: begin
                    run = $urandom_range(20, 40);
                    repeat (run) send_item(channel_e'($urandom_range(0, 1)), pick_sample());
                end
                2: begin
                    run = $urandom_range(10, 20);
                    repeat (run) begin
                        send_item(CH_LEFT, pick_sample());
                        send_item(CH_RIGHT, pick_sample());
                    end
                end
                3: begin
                    run = $urandom_range(20, 40);
                    repeat (run) send_item(ch, 16'($signed($urandom_range(0, 63)) - 32));
                end
                default: begin
                    send_item(ch, pick_sample());
                    run = $urandom_range(5, 10);
                    repeat (run) send_item(ch, 16'h0000);
                end
            endcase
            if (items_sent >= ITEM_TARGET / 2 && items_sent < ITEM_TARGET / 2 + 40) begin
                hold_until_drained();
            end
        end

        hold_until_drained();
        repeat (TAPS + 10) @(posedge aclk);
        if (board.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/sfir_pkg.sv
src/sfir_ctrl.sv
src/sfir_dp.sv
src/stereo_fir_q15_lowpass.sv
sim/stereo_fir_q15_lowpass_test.sv
